/* rtl/three_key_hash_cache_unit_assert.svh */
// Assertion macros for the three-key hash cache unit.
// Depends on nothing; the top level includes this file.
`ifndef THREE_KEY_HASH_CACHE_UNIT_ASSERT_SVH
`define THREE_KEY_HASH_CACHE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define TKHC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define TKHC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define TKHC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define TKHC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/tkhc_pkg.sv */
// Shared types, constants and the index hash of the three-key hash cache.
// Used by every module of the block; depends on nothing.
package tkhc_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int INDEX_BITS = $clog2(TABLE_ENTRIES);
   localparam int MAX_KEY_BITS = 64;
   localparam int CMD_BITS = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef logic [MAX_KEY_BITS-1:0] key_word_type;
   typedef logic [INDEX_BITS-1:0] index_type;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_FLUSH  = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   // The index folds bytes 1, 2 and 5 of the source and procedure keys with
   // byte 0 of the destination key.
   function automatic index_type hash_index(key_word_type src, key_word_type proc,
                                            key_word_type dest);
      return src[15:8] ^ src[23:16] ^ src[47:40]
           ^ proc[15:8] ^ proc[23:16] ^ proc[47:40]
           ^ dest[7:0];
   endfunction

endpackage

/* rtl/tkhc_front.sv */
// Front stage: accepts request words, computes the table index and registers
// the classified item for the queue. Depends on tkhc_pkg.
module tkhc_front #(
   parameter int KEY_BITS = 64,
   parameter int ID_BITS = 64,
   localparam int ITEM_BITS = tkhc_pkg::CMD_BITS + tkhc_pkg::INDEX_BITS
                            + 3 * KEY_BITS + ID_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [tkhc_pkg::CMD_BITS-1:0] in_cmd,
   input  logic [KEY_BITS-1:0]           in_src,
   input  logic [KEY_BITS-1:0]           in_proc,
   input  logic [KEY_BITS-1:0]           in_dest,
   input  logic [ID_BITS-1:0]            in_id,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [ITEM_BITS-1:0]          out_item
);

   localparam int WORD_BITS = tkhc_pkg::MAX_KEY_BITS;

   logic                      valid_ff;
   logic [ITEM_BITS-1:0]      item_ff;
   logic [ITEM_BITS-1:0]      item_in;
   tkhc_pkg::index_type       index;
   logic                      load;

   always_comb begin
      index = tkhc_pkg::hash_index(WORD_BITS'(in_src), WORD_BITS'(in_proc),
                                   WORD_BITS'(in_dest));
      item_in = {in_id, in_dest, in_proc, in_src, index, in_cmd};
      in_ready = !valid_ff || out_ready;
      load = in_valid && in_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item = item_ff;

endmodule

/* rtl/tkhc_queue.sv */
// Short first-in first-out queue between the front and back stages.
// Depends on tkhc_pkg for its depth.
module tkhc_queue #(
   parameter int WIDTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int DEPTH = tkhc_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS = tkhc_pkg::QUEUE_PTR_BITS;
   localparam int COUNT_BITS = tkhc_pkg::QUEUE_COUNT_BITS;

   logic [WIDTH-1:0]      slot_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff;
   logic [PTR_BITS-1:0]   rd_ptr_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic                  push;
   logic                  pop;

   always_comb begin
      push_ready = count_ff != COUNT_BITS'(DEPTH);
      pop_valid = count_ff != '0;
      push = push_valid && push_ready;
      pop = pop_valid && pop_ready;
      pop_data = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_BITS'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + COUNT_BITS'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/tkhc_back.sv */
// Back stage: table memory with written bits, key compare and result register.
// Depends on tkhc_pkg.
module tkhc_back #(
   parameter int KEY_BITS = 64,
   parameter int ID_BITS = 64,
   localparam int ITEM_BITS = tkhc_pkg::CMD_BITS + tkhc_pkg::INDEX_BITS
                            + 3 * KEY_BITS + ID_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [ITEM_BITS-1:0] in_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_hit,
   output logic [ID_BITS-1:0]   rsp_id
);

   localparam int KEYS_BITS = 3 * KEY_BITS;
   localparam int ENTRY_BITS = KEYS_BITS + ID_BITS;
   localparam int ENTRY_LSB = tkhc_pkg::CMD_BITS + tkhc_pkg::INDEX_BITS;

   logic [ENTRY_BITS-1:0]              mem [tkhc_pkg::TABLE_ENTRIES];
   logic [tkhc_pkg::TABLE_ENTRIES-1:0] written_ff;

   tkhc_pkg::cmd_type     cmd;
   tkhc_pkg::index_type   index;
   logic [ENTRY_BITS-1:0] entry;
   logic                  pop;

   logic                  s2_valid_ff;
   tkhc_pkg::cmd_type     s2_cmd_ff;
   logic [KEYS_BITS-1:0]  s2_key_ff;
   logic [ENTRY_BITS-1:0] rd_entry_ff;
   logic                  rd_written_ff;
   logic                  s2_adv;

   logic [ENTRY_BITS-1:0] stored;
   logic                  hit_in;
   logic [ID_BITS-1:0]    id_in;

   logic                  out_valid_ff;
   logic                  out_hit_ff;
   logic [ID_BITS-1:0]    out_id_ff;

   always_comb begin
      cmd = tkhc_pkg::cmd_type'(in_item[tkhc_pkg::CMD_BITS-1:0]);
      index = in_item[tkhc_pkg::CMD_BITS +: tkhc_pkg::INDEX_BITS];
      entry = in_item[ITEM_BITS-1:ENTRY_LSB];
      s2_adv = s2_valid_ff && (!out_valid_ff || rsp_ready);
      in_ready = !s2_valid_ff || s2_adv;
      pop = in_valid && in_ready;
   end

   // A never-written entry reads as all-zero keys and id.
   always_comb begin
      stored = rd_written_ff ? rd_entry_ff : '0;
      hit_in = (s2_cmd_ff == tkhc_pkg::CMD_LOOKUP)
            && (stored[KEYS_BITS-1:0] == s2_key_ff);
      id_in = hit_in ? stored[ENTRY_BITS-1:KEYS_BITS] : '0;
   end

   always_ff @(posedge clock) begin
      if (pop && cmd == tkhc_pkg::CMD_ADD) begin
         mem[index] <= entry;
      end
      if (pop) begin
         rd_entry_ff <= mem[index];
         rd_written_ff <= written_ff[index];
         s2_cmd_ff <= cmd;
         s2_key_ff <= entry[KEYS_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (pop) begin
         unique case (cmd)
            tkhc_pkg::CMD_ADD: begin
               written_ff[index] <= 1'b1;
            end
            tkhc_pkg::CMD_FLUSH: begin
               written_ff <= '0;
            end
            tkhc_pkg::CMD_LOOKUP, tkhc_pkg::CMD_NOP: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            s2_valid_ff <= in_valid;
         end
         if (s2_adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         out_hit_ff <= hit_in;
         out_id_ff <= id_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_hit = out_hit_ff;
   assign rsp_id = out_id_ff;

endmodule

/* rtl/three_key_hash_cache_unit.sv */
// Top level of the three-key hash cache: front stage, queue and back stage.
// Depends on tkhc_pkg, tkhc_front, tkhc_queue, tkhc_back and the assertion header.
//
// Requests enter on the req_ stream: req_tuser carries the command (lookup,
// add, flush, no operation), req_tdata the three key words and the id. Every
// request gives exactly one word on the rsp_ stream: rsp_tuser is the hit flag
// and rsp_tdata the stored id on a hit, zero otherwise. Add, flush and no
// operation answer with a miss and id zero.
// From request acceptance to rsp_tvalid a request passes the front register,
// the queue and the registered table read before the compare result is loaded
// into the output register.
// Throughput is one request per cycle while rsp_tready stays high; the table
// memory is read on every request and written on an add, and a lookup right
// after an add sees it. Reset clears the written bits of all 256 entries at
// once, so no clearing pass follows reset; a flush likewise clears them at once.
// When the receiver holds rsp_tready low, the output register, the compare
// stage, the two-word queue and the front register fill in turn before
// req_tready falls.
`include "three_key_hash_cache_unit_assert.svh"

module three_key_hash_cache_unit #(
   parameter int KEY_BITS = 64,
   parameter int ID_BITS = 64,
   localparam int REQ_DATA_BITS = ((3 * KEY_BITS + ID_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((ID_BITS + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // src_key, proc_key, dest_key, id_value from the lowest bit up.
   input  logic [REQ_DATA_BITS-1:0]      req_tdata,
   // cmd.
   input  logic [tkhc_pkg::CMD_BITS-1:0] req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // id_out.
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,
   // hit.
   output logic                          rsp_tuser
);

   localparam int ITEM_BITS = tkhc_pkg::CMD_BITS + tkhc_pkg::INDEX_BITS
                            + 3 * KEY_BITS + ID_BITS;

   logic                 front_valid;
   logic                 front_ready;
   logic [ITEM_BITS-1:0] front_item;
   logic                 queue_valid;
   logic                 queue_ready;
   logic [ITEM_BITS-1:0] queue_item;
   logic [ID_BITS-1:0]   rsp_id;

   tkhc_front #(
      .KEY_BITS(KEY_BITS),
      .ID_BITS(ID_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .in_cmd(req_tuser),
      .in_src(req_tdata[0 +: KEY_BITS]),
      .in_proc(req_tdata[KEY_BITS +: KEY_BITS]),
      .in_dest(req_tdata[2 * KEY_BITS +: KEY_BITS]),
      .in_id(req_tdata[3 * KEY_BITS +: ID_BITS]),
      .out_valid(front_valid),
      .out_ready(front_ready),
      .out_item(front_item)
   );

   tkhc_queue #(
      .WIDTH(ITEM_BITS)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(front_valid),
      .push_ready(front_ready),
      .push_data(front_item),
      .pop_valid(queue_valid),
      .pop_ready(queue_ready),
      .pop_data(queue_item)
   );

   tkhc_back #(
      .KEY_BITS(KEY_BITS),
      .ID_BITS(ID_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .in_valid(queue_valid),
      .in_ready(queue_ready),
      .in_item(queue_item),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .rsp_hit(rsp_tuser),
      .rsp_id(rsp_id)
   );

   assign rsp_tdata = RSP_DATA_BITS'(rsp_id);

   `TKHC_ASSERT_IMPLY(a_miss_id_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)
   `TKHC_ASSERT_NEXT(a_reset_no_rsp, clock, 1'b0, reset, !rsp_tvalid)
   `TKHC_ASSERT_NEXT(a_reset_ready, clock, 1'b0, reset, req_tready)

endmodule

/* tb/sv/three_key_hash_cache_unit_tb.sv */
// Self-checking testbench for three_key_hash_cache_unit: directed rows, then random
// add, lookup, flush and no-op words under random source bursts and sink stalls.
// Depends on tkhc_pkg and the RTL of three_key_hash_cache_unit.
module three_key_hash_cache_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WORDS = 680;
   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES = 12;
   localparam tkhc_pkg::key_word_type ALL_ONES = '1;
   localparam tkhc_pkg::key_word_type ID_SEQ = 64'h0123_4567_89AB_CDEF;
   localparam tkhc_pkg::key_word_type ID_FIVES = 64'h5555_5555_5555_5555;

   typedef struct packed {
      logic        hit;
      logic [63:0] id_out;
   } cache_answer_type;

   typedef struct packed {
      tkhc_pkg::key_word_type src_key;
      tkhc_pkg::key_word_type proc_key;
      tkhc_pkg::key_word_type dest_key;
   } key_triple_type;

   typedef struct {
      tkhc_pkg::cmd_type      cmd;
      tkhc_pkg::key_word_type src_key;
      tkhc_pkg::key_word_type proc_key;
      tkhc_pkg::key_word_type dest_key;
      tkhc_pkg::key_word_type id_value;
      bit                     typed;
      logic                   hit;
      logic [63:0]            id_out;
   } step_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // src_key, proc_key, dest_key, id_value from the lowest bit up.
   logic [255:0] req_tdata = '0;
   // cmd.
   logic [1:0]   req_tuser = tkhc_pkg::CMD_NOP;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // id_out.
   logic [63:0]  rsp_tdata;
   // hit.
   logic         rsp_tuser;

   cache_answer_type       pending_answers[$];
   key_triple_type         known_keys[$];
   bit                     slot_live [tkhc_pkg::TABLE_ENTRIES];
   tkhc_pkg::key_word_type live_src [tkhc_pkg::TABLE_ENTRIES];
   tkhc_pkg::key_word_type live_proc [tkhc_pkg::TABLE_ENTRIES];
   tkhc_pkg::key_word_type live_dest [tkhc_pkg::TABLE_ENTRIES];
   tkhc_pkg::key_word_type live_id [tkhc_pkg::TABLE_ENTRIES];
   bit                     slot_seen [tkhc_pkg::TABLE_ENTRIES];
   bit                     hold_request = 1'b0;
   int                     mismatch_count = 0;

   step_row_type directed_rows [20] = '{
      '{tkhc_pkg::CMD_ADD,    '0,       '0,       '0,       ALL_ONES, 1'b1, 1'b0, '0},
      '{tkhc_pkg::CMD_LOOKUP, '0,       '0,       '0,       '0,       1'b1, 1'b1, ALL_ONES},
      '{tkhc_pkg::CMD_ADD,    ALL_ONES, ALL_ONES, ALL_ONES, ID_SEQ,   1'b1, 1'b0, '0},
      '{tkhc_pkg::CMD_LOOKUP, ALL_ONES, ALL_ONES, ALL_ONES, '0,       1'b1, 1'b1, ID_SEQ},
      '{tkhc_pkg::CMD_LOOKUP, ALL_ONES, ALL_ONES, 64'h7FFF_FFFF_FFFF_FFFF, ALL_ONES,
        1'b1, 1'b0, '0},
      '{tkhc_pkg::CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, ALL_ONES, ALL_ONES, '0,
        1'b1, 1'b0, '0},
      '{tkhc_pkg::CMD_NOP,    ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, 1'b0, '0},
      '{tkhc_pkg::CMD_LOOKUP, ALL_ONES, ALL_ONES, ALL_ONES, '0,       1'b1, 1'b1, ID_SEQ},
      '{tkhc_pkg::CMD_FLUSH,  '0,       '0,       '0,       '0,       1'b1, 1'b0, '0},
      '{tkhc_pkg::CMD_LOOKUP, '0,       '0,       '0,       ALL_ONES, 1'b1, 1'b1, '0},
      '{tkhc_pkg::CMD_LOOKUP, ALL_ONES, ALL_ONES, ALL_ONES, '0,       1'b1, 1'b0, '0},
      '{tkhc_pkg::CMD_ADD,    64'h100,  '0,       64'h1,    ID_FIVES, 1'b1, 1'b0, '0},
      '{tkhc_pkg::CMD_LOOKUP, '0,       '0,       '0,       '0,       1'b1, 1'b0, '0},
      '{tkhc_pkg::CMD_LOOKUP, 64'h100,  '0,       64'h1,    '0,       1'b1, 1'b1, ID_FIVES},
      '{tkhc_pkg::CMD_ADD, 64'hDEAD_BEEF_0BAD_F00D, ID_SEQ, 64'hFEDC_BA98_7654_3210,
        64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, '0},
      '{tkhc_pkg::CMD_LOOKUP, 64'hDEAD_BEEF_0BAD_F00D, ID_SEQ, 64'hFEDC_BA98_7654_3210,
        '0, 1'b0, 1'b0, '0},
      '{tkhc_pkg::CMD_LOOKUP, 64'hDEAD_BEEF_0BAD_F00D, 64'h0123_4566_89AB_CDEF,
        64'hFEDC_BA98_7654_3210, '0, 1'b0, 1'b0, '0},
      '{tkhc_pkg::CMD_ADD,    64'h100,  '0,       64'h1,    '0,       1'b0, 1'b0, '0},
      '{tkhc_pkg::CMD_LOOKUP, 64'h100,  '0,       64'h1,    ALL_ONES, 1'b0, 1'b0, '0},
      '{tkhc_pkg::CMD_NOP, 64'hCAFE_F00D_1234_5678, 64'h8765_4321_0FED_CBA9,
        64'h0F0F_F0F0_3C3C_C3C3, 64'h9696_6969_A5A5_5A5A, 1'b0, 1'b0, '0}
   };

   three_key_hash_cache_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic tkhc_pkg::index_type slot_of(tkhc_pkg::key_word_type src_key,
                                                   tkhc_pkg::key_word_type proc_key,
                                                   tkhc_pkg::key_word_type dest_key);
      tkhc_pkg::key_word_type folded;
      folded = src_key ^ proc_key;
      return folded[15:8] ^ folded[23:16] ^ folded[47:40] ^ dest_key[7:0];
   endfunction

   function automatic cache_answer_type cache_access(tkhc_pkg::cmd_type cmd,
                                                     tkhc_pkg::key_word_type src_key,
                                                     tkhc_pkg::key_word_type proc_key,
                                                     tkhc_pkg::key_word_type dest_key,
                                                     tkhc_pkg::key_word_type id_value);
      cache_answer_type       answer = '0;
      tkhc_pkg::index_type    slot;
      key_triple_type         held;
      tkhc_pkg::key_word_type held_id;
      slot = slot_of(src_key, proc_key, dest_key);
      held = '0;
      held_id = '0;
      case (cmd)
         tkhc_pkg::CMD_LOOKUP: begin
            if (slot_live[slot]) begin
               held = {live_src[slot], live_proc[slot], live_dest[slot]};
               held_id = live_id[slot];
            end
            if (held == {src_key, proc_key, dest_key}) begin
               answer.hit = 1'b1;
               answer.id_out = held_id;
            end
         end
         tkhc_pkg::CMD_ADD: begin
            slot_live[slot] = 1'b1;
            live_src[slot] = src_key;
            live_proc[slot] = proc_key;
            live_dest[slot] = dest_key;
            live_id[slot] = id_value;
         end
         tkhc_pkg::CMD_FLUSH: begin
            slot_live = '{default: 1'b0};
         end
         default: begin
         end
      endcase
      return answer;
   endfunction

   function automatic tkhc_pkg::key_word_type random_key();
      case ($urandom_range(0, 3))
         0, 1: return {$urandom(), $urandom()};
         2: return {48'h0, 16'($urandom())};
         default: return {56'hFF_FFFF_FFFF_FFFF, 8'($urandom())};
      endcase
   endfunction

   task automatic offer_word(input tkhc_pkg::cmd_type cmd,
                             input tkhc_pkg::key_word_type src_key,
                             input tkhc_pkg::key_word_type proc_key,
                             input tkhc_pkg::key_word_type dest_key,
                             input tkhc_pkg::key_word_type id_value, input bit typed,
                             input logic typed_hit, input logic [63:0] typed_id);
      cache_answer_type answer;
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {id_value, dest_key, proc_key, src_key};
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      answer = cache_access(cmd, src_key, proc_key, dest_key, id_value);
      if (typed) begin
         answer.hit = typed_hit;
         answer.id_out = typed_id;
      end
      pending_answers.push_back(answer);
   endtask

   task automatic idle_sender(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic offer_random_word();
      key_triple_type      keys;
      tkhc_pkg::cmd_type   cmd;
      int                  pick;
      logic [191:0]        flip;
      tkhc_pkg::index_type slot;
      pick = $urandom_range(0, 99);
      keys = {random_key(), random_key(), random_key()};
      cmd = tkhc_pkg::CMD_ADD;
      if (pick < 45 && known_keys.size() != 0) begin
         cmd = tkhc_pkg::CMD_LOOKUP;
         keys = known_keys[$urandom_range(0, known_keys.size() - 1)];
      end else if (pick < 55 && known_keys.size() != 0) begin
         cmd = tkhc_pkg::CMD_LOOKUP;
         flip = '0;
         flip[$urandom_range(0, 191)] = 1'b1;
         keys = key_triple_type'(known_keys[$urandom_range(0, known_keys.size() - 1)] ^ flip);
      end else if (pick < 62) begin
         cmd = tkhc_pkg::CMD_LOOKUP;
      end else if (pick < 65) begin
         cmd = tkhc_pkg::CMD_NOP;
      end else if (pick < 67) begin
         cmd = tkhc_pkg::CMD_FLUSH;
      end else if (pick < 69) begin
         cmd = tkhc_pkg::CMD_LOOKUP;
         keys = '0;
      end
      slot = slot_of(keys.src_key, keys.proc_key, keys.dest_key);
      if (cmd == tkhc_pkg::CMD_LOOKUP && !slot_seen[slot]) cmd = tkhc_pkg::CMD_ADD;
      if (cmd == tkhc_pkg::CMD_ADD) begin
         slot_seen[slot] = 1'b1;
         known_keys.push_back(keys);
         if (known_keys.size() > 32) void'(known_keys.pop_front());
      end
      if (cmd == tkhc_pkg::CMD_FLUSH) known_keys.delete();
      offer_word(cmd, keys.src_key, keys.proc_key, keys.dest_key, {$urandom(), $urandom()},
                 1'b0, 1'b0, '0);
   endtask

   always @(posedge clock) begin
      cache_answer_type expected;
      if (reset === 1'b0 && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_answers.size() == 0) begin
            $error("rsp word with no pending request: hit %0b, id_out %h",
                   rsp_tuser, rsp_tdata);
            mismatch_count++;
         end else begin
            expected = pending_answers.pop_front();
            if (rsp_tuser !== expected.hit) begin
               $error("hit mismatch: expected %0b, got %0b", expected.hit, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tdata !== expected.id_out) begin
               $error("id_out mismatch: expected %h, got %h", expected.id_out, rsp_tdata);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int span;
      int mode;
      int phase;
      phase = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 40);
            repeat (span) begin
               case (mode)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= ($urandom_range(0, 3) != 0);
                  2: rsp_tready <= (phase % 3 != 0);
                  default: rsp_tready <= $urandom_range(0, 1);
               endcase
               phase++;
               @(posedge clock);
               if (hold_request) break;
            end
         end
      end
   end

   initial begin
      #5ms;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int  sent;
      int  burst;
      int  gap;
      bit  held;
      bit  paused;
      sent = 0;
      held = 1'b0;
      paused = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         offer_word(directed_rows[i].cmd, directed_rows[i].src_key, directed_rows[i].proc_key,
                    directed_rows[i].dest_key, directed_rows[i].id_value,
                    directed_rows[i].typed, directed_rows[i].hit, directed_rows[i].id_out);
         slot_seen[slot_of(directed_rows[i].src_key, directed_rows[i].proc_key,
                           directed_rows[i].dest_key)] |=
            (directed_rows[i].cmd == tkhc_pkg::CMD_ADD);
      end
      wait_drained();
      while (sent < RANDOM_WORDS) begin
         if (!held && sent >= 200) begin
            held = 1'b1;
            hold_request = 1'b1;
            repeat (24) offer_random_word();
            sent += 24;
         end
         if (!paused && sent >= 450) begin
            paused = 1'b1;
            wait_drained();
         end
         burst = $urandom_range(1, 24);
         repeat (burst) offer_random_word();
         sent += burst;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) idle_sender(gap);
      end
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
